@@ hw/rtl/dcq_pkg.sv @@
package dcq_pkg;

  // Fixed field widths.
  localparam int DATA_W        = 32;
  localparam int ARG_W         = 36;
  localparam int NUM_W         = 33;
  localparam int ROOT_W        = 32;
  localparam int X_W           = 64;
  localparam int NUM_LANES     = 3;
  localparam int FRAC_BITS_DEF = 30;

  // Branch codes.
  localparam logic [1:0] BR_Q1    = 2'd0;
  localparam logic [1:0] BR_Q2    = 2'd1;
  localparam logic [1:0] BR_Q3    = 2'd2;
  localparam logic [1:0] BR_TRACE = 2'd3;

  // Data that rides along the square-root pipeline.
  typedef struct packed {
    logic [1:0]              branch;
    logic signed [NUM_W-1:0] num2;
    logic signed [NUM_W-1:0] num1;
    logic signed [NUM_W-1:0] num0;
  } dcq_side_t;

endpackage

@@ hw/rtl/dcq_front.sv @@
module dcq_front #(
  parameter int FRAC_BITS = dcq_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [dcq_pkg::DATA_W-1:0] c11, c12, c13, c21, c22, c23, c31, c32, c33,
  output logic                              out_valid,
  output logic [dcq_pkg::X_W-1:0]           out_x,
  output dcq_pkg::dcq_side_t                out_side
);
  import dcq_pkg::*;

  localparam logic signed [ARG_W-1:0] ONE_A = ARG_W'(1) << FRAC_BITS;

  function automatic logic signed [ARG_W-1:0] sx(input logic signed [DATA_W-1:0] v);
    return {{(ARG_W-DATA_W){v[DATA_W-1]}}, v};
  endfunction

  function automatic logic signed [NUM_W-1:0] nx(input logic signed [DATA_W-1:0] v);
    return {v[DATA_W-1], v};
  endfunction

  // Stage 1: branch tests, root arguments and all numerators.
  logic                    v1_r;
  logic                    ge0_r, ge1_r, ge2_r;
  logic signed [ARG_W-1:0] arg0_r, arg1_r, arg2_r, arg3_r;
  logic signed [NUM_W-1:0] na_r, nb_r, nc_r, nd_r, ne_r, nf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ge0_r  <= sx(c11) >= sx(c22) + sx(c33);
      ge1_r  <= sx(c22) >= sx(c11) + sx(c33);
      ge2_r  <= sx(c33) >= sx(c11) + sx(c22);
      arg0_r <= ONE_A + sx(c11) - sx(c22) - sx(c33);
      arg1_r <= ONE_A - sx(c11) + sx(c22) - sx(c33);
      arg2_r <= ONE_A - sx(c11) - sx(c22) + sx(c33);
      arg3_r <= ONE_A + sx(c11) + sx(c22) + sx(c33);
      na_r   <= nx(c32) - nx(c23);
      nb_r   <= nx(c12) + nx(c21);
      nc_r   <= nx(c13) + nx(c31);
      nd_r   <= nx(c13) - nx(c31);
      ne_r   <= nx(c23) + nx(c32);
      nf_r   <= nx(c21) - nx(c12);
    end
  end

  // Stage 2: branch select, clamp, and scale of the root argument.
  logic [1:0]              br;
  logic signed [ARG_W-1:0] arg_sel;
  logic [ARG_W-1:0]        arg_clamp;
  dcq_side_t               side;

  always_comb begin
    if (ge0_r)      br = BR_Q1;
    else if (ge1_r) br = BR_Q2;
    else if (ge2_r) br = BR_Q3;
    else            br = BR_TRACE;
  end

  always_comb begin
    side.branch = br;
    unique case (br)
      BR_Q1: begin
        arg_sel   = arg0_r;
        side.num0 = na_r; side.num1 = nb_r; side.num2 = nc_r;
      end
      BR_Q2: begin
        arg_sel   = arg1_r;
        side.num0 = nd_r; side.num1 = nb_r; side.num2 = ne_r;
      end
      BR_Q3: begin
        arg_sel   = arg2_r;
        side.num0 = nf_r; side.num1 = nc_r; side.num2 = ne_r;
      end
      default: begin
        arg_sel   = arg3_r;
        side.num0 = na_r; side.num1 = nd_r; side.num2 = nf_r;
      end
    endcase
    arg_clamp = arg_sel[ARG_W-1] ? '0 : arg_sel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x    <= X_W'(arg_clamp) << (FRAC_BITS - 2);
      out_side <= side;
    end
  end

endmodule

@@ hw/rtl/dcq_sqrt.sv @@
module dcq_sqrt #(
  parameter int SW = $bits(dcq_pkg::dcq_side_t)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [dcq_pkg::X_W-1:0]      in_x,
  input  logic [SW-1:0]                in_side,
  output logic                         out_valid,
  output logic [dcq_pkg::ROOT_W-1:0]   out_root,
  output logic [SW-1:0]                out_side
);
  import dcq_pkg::*;

  // One root bit per stage, two radicand bits consumed per stage.
  localparam int STEPS = X_W / 2;
  localparam int REM_W = ROOT_W + 4;

  logic             v_s    [0:STEPS];
  logic [X_W-1:0]   x_s    [0:STEPS];
  logic [REM_W-1:0] rem_s  [0:STEPS];
  logic [ROOT_W-1:0] root_s [0:STEPS];
  logic [SW-1:0]    side_s [0:STEPS];

  assign v_s[0]    = in_valid;
  assign x_s[0]    = in_x;
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign side_s[0] = in_side;

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [REM_W-1:0] rem_sh, trial;
    logic             ge;

    // Restoring step: try subtracting 4*root+1 from the shifted remainder.
    always_comb begin
      rem_sh = {rem_s[k][REM_W-3:0], x_s[k][X_W-1 -: 2]};
      trial  = REM_W'({root_s[k], 2'b01});
      ge     = rem_sh >= trial;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_s[k+1] <= 1'b0;
      end else if (en) begin
        v_s[k+1] <= v_s[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_s[k+1]    <= x_s[k] << 2;
        rem_s[k+1]  <= ge ? rem_sh - trial : rem_sh;
        root_s[k+1] <= {root_s[k][ROOT_W-2:0], ge};
        side_s[k+1] <= side_s[k];
      end
    end
  end

  assign out_valid = v_s[STEPS];
  assign out_root  = root_s[STEPS];
  assign out_side  = side_s[STEPS];

endmodule

@@ hw/rtl/dcq_div.sv @@
module dcq_div #(
  parameter int FRAC_BITS = dcq_pkg::FRAC_BITS_DEF,
  parameter int SW        = 2
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [dcq_pkg::ROOT_W-1:0]          in_root,
  input  logic signed [dcq_pkg::NUM_W-1:0]    in_num [dcq_pkg::NUM_LANES],
  input  logic [SW-1:0]                       in_side,
  output logic                                out_valid,
  output logic signed [dcq_pkg::DATA_W-1:0]   out_comp,
  output logic signed [dcq_pkg::DATA_W-1:0]   out_q [dcq_pkg::NUM_LANES],
  output logic [SW-1:0]                       out_side
);
  import dcq_pkg::*;

  // One quotient bit per stage over the full dividend.
  localparam int STEPS = X_W;
  localparam int RW    = FRAC_BITS + 3;
  localparam logic [ROOT_W-1:0] ONE_R = ROOT_W'(1) << FRAC_BITS;
  localparam logic [X_W-1:0]    ONE_Q = X_W'(1) << FRAC_BITS;
  localparam logic signed [DATA_W-1:0] ONE_D = DATA_W'(1) << FRAC_BITS;

  logic             v_s    [0:STEPS];
  logic [RW-1:0]    d_s    [0:STEPS];
  logic             z_s    [0:STEPS];
  logic [ROOT_W-1:0] comp_s [0:STEPS];
  logic [SW-1:0]    side_s [0:STEPS];
  logic [NUM_LANES-1:0] neg_s [0:STEPS];
  logic [X_W-1:0]   n_s    [0:STEPS][NUM_LANES];
  logic [RW-1:0]    rem_s  [0:STEPS][NUM_LANES];
  logic [X_W-1:0]   q_s    [0:STEPS][NUM_LANES];

  // Prep stage: saturate the root, form the divisor and magnitudes.
  logic [ROOT_W-1:0] comp_sat;
  assign comp_sat = (in_root > ONE_R) ? ONE_R : in_root;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_s[0] <= 1'b0;
    end else if (en) begin
      v_s[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      comp_s[0] <= comp_sat;
      d_s[0]    <= {comp_sat[RW-3:0], 2'b00};
      z_s[0]    <= comp_sat == '0;
      side_s[0] <= in_side;
      for (int l = 0; l < NUM_LANES; l++) begin
        neg_s[0][l] <= in_num[l][NUM_W-1];
        // The magnitude is unsigned: a numerator of -2^32 keeps its top bit.
        n_s[0][l]   <= X_W'($unsigned(in_num[l][NUM_W-1] ? NUM_W'(-in_num[l])
                                                         : NUM_W'(in_num[l])))
                       << FRAC_BITS;
        rem_s[0][l] <= '0;
        q_s[0][l]   <= '0;
      end
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_s[k+1] <= 1'b0;
      end else if (en) begin
        v_s[k+1] <= v_s[k];
      end
    end

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      logic [RW-1:0] rem_sh;
      logic          ge;

      // Restoring step: bring down one dividend bit and try the divisor.
      always_comb begin
        rem_sh = {rem_s[k][l][RW-2:0], n_s[k][l][X_W-1]};
        ge     = rem_sh >= d_s[k];
      end

      always_ff @(posedge clk) begin
        if (en) begin
          n_s[k+1][l]   <= n_s[k][l] << 1;
          rem_s[k+1][l] <= ge ? rem_sh - d_s[k] : rem_sh;
          q_s[k+1][l]   <= {q_s[k][l][X_W-2:0], ge};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_s[k+1]    <= d_s[k];
        z_s[k+1]    <= z_s[k];
        comp_s[k+1] <= comp_s[k];
        side_s[k+1] <= side_s[k];
        neg_s[k+1]  <= neg_s[k];
      end
    end
  end

  // Final stage: saturation, zero divisor, sign.
  logic signed [DATA_W-1:0] res [NUM_LANES];

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      if (z_s[STEPS]) begin
        res[l] = neg_s[STEPS][l] ? -ONE_D : ONE_D;
      end else if (q_s[STEPS][l] > ONE_Q) begin
        res[l] = neg_s[STEPS][l] ? -ONE_D : ONE_D;
      end else begin
        res[l] = neg_s[STEPS][l] ? -DATA_W'(q_s[STEPS][l]) : DATA_W'(q_s[STEPS][l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_s[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_comp <= DATA_W'(comp_s[STEPS]);
      out_side <= side_s[STEPS];
      for (int l = 0; l < NUM_LANES; l++) begin
        out_q[l] <= res[l];
      end
    end
  end

endmodule

@@ hw/rtl/direction_cosine_to_quaternion_unit.sv @@
// Channel | Dir | Ports                         | Content
// in      | in  | in_tvalid/in_tready/in_tdata  | nine matrix entries, Q2.30
// out     | out | out_tvalid/out_tready/out_tdata/out_tuser | quaternion, branch
//
// One matrix is accepted every cycle while not stalled. The pipeline is two
// front stages, 32 square-root stages (one root bit each), a prep stage, 64
// divider stages (one quotient bit each, three lanes side by side), a final
// saturation stage and the output register. Reset is synchronous, active low,
// and clears only the valid bits. An output stall freezes the whole pipeline.
module direction_cosine_to_quaternion_unit #(
  parameter int FRAC_BITS = dcq_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // Fields from bit 0: c11, c12, c13, c21, c22, c23, c31, c32, c33.
  input  logic [287:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // Fields from bit 0: q_scalar, q_x, q_y, q_z.
  output logic [127:0] out_tdata,
  // Fields from bit 0: branch_taken.
  output logic [1:0]   out_tuser
);
  import dcq_pkg::*;

  localparam logic signed [DATA_W-1:0] ONE_D = DATA_W'(1) << FRAC_BITS;

  logic en;
  assign en        = out_tready || !out_tvalid;
  assign in_tready = en;

  // Front: branch choice and root argument.
  logic             f_valid;
  logic [X_W-1:0]   f_x;
  dcq_side_t        f_side;

  dcq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_tvalid && in_tready),
    .c11(in_tdata[31:0]),    .c12(in_tdata[63:32]),   .c13(in_tdata[95:64]),
    .c21(in_tdata[127:96]),  .c22(in_tdata[159:128]), .c23(in_tdata[191:160]),
    .c31(in_tdata[223:192]), .c32(in_tdata[255:224]), .c33(in_tdata[287:256]),
    .out_valid(f_valid), .out_x(f_x), .out_side(f_side)
  );

  // Square root.
  logic              s_valid;
  logic [ROOT_W-1:0] s_root;
  dcq_side_t         s_side;

  dcq_sqrt #(.SW($bits(dcq_side_t))) u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(f_valid), .in_x(f_x),
    .in_side(f_side), .out_valid(s_valid), .out_root(s_root), .out_side(s_side)
  );

  // Three quotients.
  logic signed [NUM_W-1:0]  nums [NUM_LANES];
  logic                     d_valid;
  logic signed [DATA_W-1:0] d_comp;
  logic signed [DATA_W-1:0] d_q [NUM_LANES];
  logic [1:0]               d_br;

  assign nums[0] = s_side.num0;
  assign nums[1] = s_side.num1;
  assign nums[2] = s_side.num2;

  dcq_div #(.FRAC_BITS(FRAC_BITS), .SW(2)) u_div (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s_valid), .in_root(s_root),
    .in_num(nums), .in_side(s_side.branch), .out_valid(d_valid),
    .out_comp(d_comp), .out_q(d_q), .out_side(d_br)
  );

  // Output register: place the components by branch.
  logic [127:0] data_nxt;

  always_comb begin
    unique case (d_br)
      BR_Q1:   data_nxt = {d_q[2], d_q[1], d_comp, d_q[0]};
      BR_Q2:   data_nxt = {d_q[2], d_comp, d_q[1], d_q[0]};
      BR_Q3:   data_nxt = {d_comp, d_q[2], d_q[1], d_q[0]};
      default: data_nxt = {d_q[2], d_q[1], d_q[0], d_comp};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (en) begin
      out_tvalid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata <= data_nxt;
      out_tuser <= d_br;
    end
  end

  // The input may only be taken when the output register can move.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (out_tready || !out_tvalid))
    else $error("in_tready does not follow the output stall");

  // The root component of the trace branch is never negative and at most one.
  a_root: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == BR_TRACE) |->
      !out_tdata[31] && ($signed(out_tdata[31:0]) <= ONE_D))
    else $error("trace branch root out of range");

  // No result leaves right after reset.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule
